### sv/aabb_pkg.sv
// aabb_pkg: action codes, sequencer step constants and command/status
// structs shared by the box unit controller, datapath and top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package aabb_pkg;

  localparam int STEP_W = 4;

  localparam logic [2:0] ACT_SET    = 3'd0;
  localparam logic [2:0] ACT_EXT_PT = 3'd1;
  localparam logic [2:0] ACT_EXT_BX = 3'd2;
  localparam logic [2:0] ACT_TST_PT = 3'd3;
  localparam logic [2:0] ACT_TST_BX = 3'd4;
  localparam logic [2:0] ACT_SPHERE = 3'd5;
  localparam logic [2:0] ACT_LINE   = 3'd6;

  // last multiply step of each multiplying action
  localparam logic [STEP_W-1:0] SPH_LAST  = 4'd3;
  localparam logic [STEP_W-1:0] LINE_LAST = 4'd11;

  // sphere step that squares the radius
  localparam logic [1:0] SPH_RAD = 2'd3;

  typedef struct packed {
    logic              load;
    logic              prep;
    logic              mul;
    logic [STEP_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic              is_mul;
    logic [STEP_W-1:0] last_step;
  } status_t;

  // axis pairs (i,j), i != j, for the slab cross checks
  function automatic logic [1:0] pair_i(input logic [2:0] p);
    logic [1:0] r;
    case (p)
      3'd0, 3'd1: r = 2'd0;
      3'd2, 3'd3: r = 2'd1;
      default:    r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] pair_j(input logic [2:0] p);
    logic [1:0] r;
    case (p)
      3'd0:       r = 2'd1;
      3'd1:       r = 2'd2;
      3'd2:       r = 2'd0;
      3'd3:       r = 2'd2;
      3'd4:       r = 2'd0;
      default:    r = 2'd1;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### sv/aabb_bounds_and_intersection.sv
// aabb_bounds_and_intersection: top level of the bounding box unit.
// Instances aabb_ctrl and aabb_dp; uses aabb_pkg.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+----------------------
//  request  | in_action, in_a_*, in_b_*, in_radius    | start & !busy
//  result   | out_hit                                 | out_valid, 1 cycle
//
// Per request: set, extend, point and box tests go from acceptance through prepare to
// out_valid; sphere adds 4 products and line 12 cross products, all through the one
// shared signed multiplier which yields one product per cycle, and then a drain step.
// busy drops the cycle after out_valid.
// Reset (rst_n low, synchronous) clears the box to zero and the sequencer.
// The receiver cannot stall; one request is in flight at a time.
`timescale 1ns / 1ps
`default_nettype none
module aabb_bounds_and_intersection
  import aabb_pkg::*;
#(
  parameter int COORD_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic        [2:0]  in_action,
  input  wire logic signed [31:0] in_a_x,
  input  wire logic signed [31:0] in_a_y,
  input  wire logic signed [31:0] in_a_z,
  input  wire logic signed [31:0] in_b_x,
  input  wire logic signed [31:0] in_b_y,
  input  wire logic signed [31:0] in_b_z,
  input  wire logic        [30:0] in_radius,
  output logic                    out_valid,
  output logic                    out_hit
);

  cmd_t    cmd;
  status_t status;

  // sequencer: one request at a time, steps the multiplier
  aabb_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (out_valid)
  );

  // box state, compare lanes, multiplier, result flag
  aabb_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_action (in_action),
    .in_a_x    (in_a_x),
    .in_a_y    (in_a_y),
    .in_a_z    (in_a_z),
    .in_b_x    (in_b_x),
    .in_b_y    (in_b_y),
    .in_b_z    (in_b_z),
    .in_radius (in_radius),
    .hit       (out_hit)
  );

`ifndef NO_ASSERTIONS
  // a result only comes while a request is in flight
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result without request");

  // an accepted request makes the unit busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accept did not set busy");

  // one result per request: the strobe is never repeated
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe repeated");

  // multiply commands never overlap load or prepare
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul |-> !(cmd.load || cmd.prep)) else $error("command overlap");
`endif

endmodule
`default_nettype wire

### sv/aabb_ctrl.sv
// aabb_ctrl: sequencer for the box unit (load, prepare, multiply steps,
// drain, result). Depends on aabb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module aabb_ctrl
  import aabb_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  input  wire status_t status,
  output cmd_t         cmd,
  output logic         busy,
  output logic         done
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PREP  = 5'b00010,
    S_MUL   = 5'b00100,
    S_DRAIN = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_PREP;
      end
      S_PREP: begin
        step_nxt  = '0;
        state_nxt = status.is_mul ? S_MUL : S_DONE;
      end
      S_MUL: begin
        if (step_r == status.last_step) state_nxt = S_DRAIN;
        else step_nxt = step_r + 1'b1;
      end
      S_DRAIN: state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  assign cmd.load = (state_r == S_IDLE) && start;
  assign cmd.prep = (state_r == S_PREP);
  assign cmd.mul  = (state_r == S_MUL);
  assign cmd.step = step_r;
  assign busy     = (state_r != S_IDLE);
  assign done     = (state_r == S_DONE);

endmodule
`default_nettype wire

### sv/aabb_dp.sv
// aabb_dp: box registers, per-axis compare lanes, shared signed multiplier
// and result flag. Depends on aabb_pkg; driven by aabb_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none
module aabb_dp
  import aabb_pkg::*;
#(
  parameter int COORD_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cmd_t               cmd,
  output status_t                 status,
  input  wire logic        [2:0]  in_action,
  input  wire logic signed [31:0] in_a_x,
  input  wire logic signed [31:0] in_a_y,
  input  wire logic signed [31:0] in_a_z,
  input  wire logic signed [31:0] in_b_x,
  input  wire logic signed [31:0] in_b_y,
  input  wire logic signed [31:0] in_b_z,
  input  wire logic        [30:0] in_radius,
  output logic                    hit
);

  localparam int CW = (COORD_BITS < 32) ? COORD_BITS : 32;
  localparam int DW = CW + 1;
  localparam int MW = (DW > 32) ? DW : 32;
  localparam int PW = 2 * MW;
  localparam int AW = PW + 2;

  logic        [2:0]    act_r;
  logic signed [CW-1:0] a_r [3];
  logic signed [CW-1:0] b_r [3];
  logic        [30:0]   rad_r;
  logic signed [CW-1:0] mn_r [3];
  logic signed [CW-1:0] mx_r [3];

  logic signed [DW-1:0] lo_r [3];
  logic signed [DW-1:0] hi_r [3];
  logic signed [DW-1:0] den_r [3];
  logic signed [DW-1:0] sd_r [3];
  logic        [2:0]    live_r;

  logic signed [PW-1:0]     prod_r;
  logic signed [PW-1:0]     hold_r;
  logic        [AW-1:0]     acc_r;
  logic        [STEP_W-1:0] kd_r;
  logic                     pv_r;
  logic                     res_r;

  // per-axis lane results
  logic signed [DW-1:0] d_c [3];
  logic signed [DW-1:0] n1_c [3];
  logic signed [DW-1:0] n2_c [3];
  logic signed [DW-1:0] lo_c [3];
  logic signed [DW-1:0] hi_c [3];
  logic signed [DW-1:0] den_c [3];
  logic signed [DW-1:0] sd_c [3];
  logic signed [CW-1:0] p_c [3];
  logic signed [CW-1:0] bl_c [3];
  logic signed [CW-1:0] bh_c [3];
  logic signed [CW-1:0] e1mn_c [3];
  logic signed [CW-1:0] e1mx_c [3];
  logic signed [CW-1:0] e2mn_c [3];
  logic signed [CW-1:0] e2mx_c [3];
  logic        [2:0]    live_c;
  logic        [2:0]    slab_c;
  logic        [2:0]    pt_c;
  logic        [2:0]    ovl_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_c[i]  = $signed({b_r[i][CW-1], b_r[i]}) - $signed({a_r[i][CW-1], a_r[i]});
      n1_c[i] = $signed({mn_r[i][CW-1], mn_r[i]}) - $signed({a_r[i][CW-1], a_r[i]});
      n2_c[i] = $signed({mx_r[i][CW-1], mx_r[i]}) - $signed({a_r[i][CW-1], a_r[i]});
      if (d_c[i][DW-1]) begin
        n1_c[i]  = -n1_c[i];
        n2_c[i]  = -n2_c[i];
        den_c[i] = -d_c[i];
      end else begin
        den_c[i] = d_c[i];
      end
      live_c[i] = (d_c[i] != '0);
      lo_c[i]   = (n1_c[i] < n2_c[i]) ? n1_c[i] : n2_c[i];
      hi_c[i]   = (n1_c[i] < n2_c[i]) ? n2_c[i] : n1_c[i];
      bl_c[i]   = (mn_r[i] < mx_r[i]) ? mn_r[i] : mx_r[i];
      bh_c[i]   = (mn_r[i] < mx_r[i]) ? mx_r[i] : mn_r[i];
      slab_c[i] = live_c[i] || ((a_r[i] >= bl_c[i]) && (a_r[i] <= bh_c[i]));
      // sphere: clamp center into the box, keep the offset
      p_c[i]    = (a_r[i] < mn_r[i]) ? mn_r[i] : a_r[i];
      p_c[i]    = (p_c[i] > mx_r[i]) ? mx_r[i] : p_c[i];
      sd_c[i]   = $signed({a_r[i][CW-1], a_r[i]}) - $signed({p_c[i][CW-1], p_c[i]});
      pt_c[i]   = (a_r[i] >= mn_r[i]) && (a_r[i] <= mx_r[i]);
      ovl_c[i]  = !((a_r[i] > mx_r[i]) || (b_r[i] < mn_r[i]));
      e1mn_c[i] = (a_r[i] < mn_r[i]) ? a_r[i] : mn_r[i];
      e1mx_c[i] = (a_r[i] > mx_r[i]) ? a_r[i] : mx_r[i];
      e2mn_c[i] = (b_r[i] < e1mn_c[i]) ? b_r[i] : e1mn_c[i];
      e2mx_c[i] = (b_r[i] > e1mx_c[i]) ? b_r[i] : e1mx_c[i];
    end
  end

  // shared multiplier operand select
  logic signed [MW-1:0] ma, mb;
  logic signed [PW-1:0] mprod;
  logic        [1:0]    si, sj, ki, kj;

  assign si = pair_i(cmd.step[3:1]);
  assign sj = pair_j(cmd.step[3:1]);
  assign ki = pair_i(kd_r[3:1]);
  assign kj = pair_j(kd_r[3:1]);

  always_comb begin
    if (act_r == ACT_SPHERE) begin
      if (cmd.step[1:0] == SPH_RAD) begin
        ma = MW'($signed({1'b0, rad_r}));
        mb = MW'($signed({1'b0, rad_r}));
      end else begin
        ma = MW'(sd_r[cmd.step[1:0]]);
        mb = MW'(sd_r[cmd.step[1:0]]);
      end
    end else if (!cmd.step[0]) begin
      ma = MW'(lo_r[si]);
      mb = MW'(den_r[sj]);
    end else begin
      ma = MW'(hi_r[sj]);
      mb = MW'(den_r[si]);
    end
  end

  assign mprod = ma * mb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        mn_r[i] <= '0;
        mx_r[i] <= '0;
      end
      pv_r  <= 1'b0;
      res_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        act_r  <= in_action;
        a_r[0] <= in_a_x[CW-1:0];
        a_r[1] <= in_a_y[CW-1:0];
        a_r[2] <= in_a_z[CW-1:0];
        b_r[0] <= in_b_x[CW-1:0];
        b_r[1] <= in_b_y[CW-1:0];
        b_r[2] <= in_b_z[CW-1:0];
        rad_r  <= in_radius;
      end
      if (cmd.prep) begin
        lo_r   <= lo_c;
        hi_r   <= hi_c;
        den_r  <= den_c;
        sd_r   <= sd_c;
        live_r <= live_c;
        acc_r  <= '0;
        case (act_r)
          ACT_SET: begin
            mn_r  <= a_r;
            mx_r  <= b_r;
            res_r <= 1'b0;
          end
          ACT_EXT_PT: begin
            mn_r  <= e1mn_c;
            mx_r  <= e1mx_c;
            res_r <= 1'b0;
          end
          ACT_EXT_BX: begin
            mn_r  <= e2mn_c;
            mx_r  <= e2mx_c;
            res_r <= 1'b0;
          end
          ACT_TST_PT: res_r <= &pt_c;
          ACT_TST_BX: res_r <= &ovl_c;
          ACT_SPHERE: res_r <= 1'b1;
          ACT_LINE:   res_r <= &slab_c;
          default:    res_r <= 1'b0;
        endcase
      end
      pv_r <= cmd.mul;
      if (cmd.mul) begin
        prod_r <= mprod;
        kd_r   <= cmd.step;
      end
      if (pv_r) begin
        if (act_r == ACT_SPHERE) begin
          if (kd_r[1:0] == SPH_RAD) res_r <= res_r && (acc_r <= {2'b00, prod_r});
          else acc_r <= acc_r + {2'b00, prod_r};
        end else if (!kd_r[0]) begin
          hold_r <= prod_r;
        end else if (live_r[ki] && live_r[kj] && (hold_r > prod_r)) begin
          res_r <= 1'b0;
        end
      end
    end
  end

  assign status.is_mul    = (act_r == ACT_SPHERE) || (act_r == ACT_LINE);
  assign status.last_step = (act_r == ACT_SPHERE) ? SPH_LAST : LINE_LAST;
  assign hit              = res_r;

endmodule
`default_nettype wire

### test/aabb_bounds_and_intersection_test.sv
// Self-checking bench for aabb_bounds_and_intersection: random and directed box requests,
// hit predicted by an in-bench box model and checked by a small scoreboard class.
// Depends on aabb_pkg and the block's RTL only.
`timescale 1ns / 1ps
module aabb_bounds_and_intersection_test;
  import aabb_pkg::*;

  typedef longint coord3_t[3];

  // Box model plus the queue of hits still owed by the block.
  class box_scoreboard;
    longint bmin[3];
    longint bmax[3];
    bit hit_q[$];
    int mismatches;
    int checked;

    function new();
      foreach (bmin[i]) begin
        bmin[i] = 0;
        bmax[i] = 0;
      end
      mismatches = 0;
      checked = 0;
    endfunction

    function automatic longint lmin(longint x, longint y);
      return x < y ? x : y;
    endfunction

    function automatic longint lmax(longint x, longint y);
      return x > y ? x : y;
    endfunction

    function automatic void grow(coord3_t p);
      foreach (p[i]) begin
        bmin[i] = lmin(bmin[i], p[i]);
        bmax[i] = lmax(bmax[i], p[i]);
      end
    endfunction

    // Exact slab test: parameters compared by cross multiplication.
    function automatic bit line_hits(coord3_t s, coord3_t e);
      longint lo[3], hi[3], den[3], d, n1, n2;
      bit live[3];
      logic signed [127:0] x, y, l, r;
      for (int i = 0; i < 3; i++) begin
        d = e[i] - s[i];
        live[i] = (d != 0);
        if (!live[i]) begin
          // still start: must sit inside the slab, bounds in either order
          if (s[i] < lmin(bmin[i], bmax[i]) || s[i] > lmax(bmin[i], bmax[i])) return 0;
        end else begin
          n1 = bmin[i] - s[i];
          n2 = bmax[i] - s[i];
          if (d < 0) begin
            n1 = -n1;
            n2 = -n2;
            d = -d;
          end
          lo[i] = lmin(n1, n2);
          hi[i] = lmax(n1, n2);
          den[i] = d;
        end
      end
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          if (i != j && live[i] && live[j]) begin
            x = lo[i]; y = den[j]; l = x * y;
            x = hi[j]; y = den[i]; r = x * y;
            if (l > r) return 0;
          end
      return 1;
    endfunction

    function automatic bit box_hit(logic [2:0] act, coord3_t a, coord3_t b, longint rad);
      bit h;
      longint p, off;
      logic [127:0] sum, dd, rr;
      h = 0;
      case (act)
        ACT_SET: begin
          bmin = a;
          bmax = b;
        end
        ACT_EXT_PT: grow(a);
        ACT_EXT_BX: begin
          grow(a);
          grow(b);
        end
        ACT_TST_PT: begin
          h = 1;
          foreach (a[i]) if (a[i] < bmin[i] || a[i] > bmax[i]) h = 0;
        end
        ACT_TST_BX: begin
          h = 1;
          foreach (a[i]) if (a[i] > bmax[i] || b[i] < bmin[i]) h = 0;
        end
        ACT_SPHERE: begin
          sum = 0;
          foreach (a[i]) begin
            p = a[i];
            if (p < bmin[i]) p = bmin[i];
            if (p > bmax[i]) p = bmax[i];
            off = a[i] - p;
            if (off < 0) off = -off;
            dd = off;
            sum += dd * dd;
          end
          rr = rad;
          h = (sum <= rr * rr);
        end
        ACT_LINE: h = line_hits(a, b);
        default: ;
      endcase
      return h;
    endfunction

    function void note_request(logic [2:0] act, coord3_t a, coord3_t b, longint rad);
      hit_q.push_back(box_hit(act, a, b, rad));
    endfunction

    function void check_hit(bit got);
      bit want;
      checked++;
      if (hit_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result hit=%0b with no request pending", got);
        return;
      end
      want = hit_q.pop_front();
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result %0d hit expected %0b actual %0b",
                                       checked, want, got);
      end
    endfunction
  endclass

  localparam int STALL_LIMIT = 4000;
  localparam int N_RANDOM    = 1500;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic [2:0] in_action = ACT_SET;
  logic signed [31:0] in_a_x = 0, in_a_y = 0, in_a_z = 0;
  logic signed [31:0] in_b_x = 0, in_b_y = 0, in_b_z = 0;
  logic [30:0] in_radius = 0;
  logic out_valid;
  logic out_hit;

  box_scoreboard sb = new();
  int sent = 0;
  int act_count[8];
  int idle_cycles = 0;

  always #6 clk = ~clk;

  aabb_bounds_and_intersection dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action),
    .in_a_x(in_a_x), .in_a_y(in_a_y), .in_a_z(in_a_z),
    .in_b_x(in_b_x), .in_b_y(in_b_y), .in_b_z(in_b_z),
    .in_radius(in_radius),
    .out_valid(out_valid), .out_hit(out_hit)
  );

  // Result side: one strobe cycle per request, no backpressure possible.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_hit(out_hit);
  end

  // Watchdog: cycles with neither a request nor a result accepted.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Drive one request at the falling edge, hold it until start & !busy at a rising edge.
  task automatic send_req(logic [2:0] act, coord3_t a, coord3_t b, longint rad);
    @(negedge clk);
    in_action = act;
    in_a_x = a[0]; in_a_y = a[1]; in_a_z = a[2];
    in_b_x = b[0]; in_b_y = b[1]; in_b_z = b[2];
    in_radius = rad[30:0];
    start = 1;
    do @(posedge clk); while (busy);
    sb.note_request(act, a, b, rad);
    sent++;
    act_count[act]++;
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      @(negedge clk);
      start = 0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Mostly short gaps, some long, long runs of back-to-back requests.
  function automatic int pick_gap(bit bursty);
    int r;
    if (bursty) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Coordinate mix: small Q16.16 values, extremes, and full random words.
  function automatic longint pick_coord();
    int r;
    logic signed [31:0] w;
    r = $urandom_range(0, 9);
    case (r)
      0: w = 32'sh8000_0000;
      1: w = 32'sh7fff_ffff;
      2, 3: w = $urandom;
      default: w = $signed($urandom_range(0, 32'h000c_0000)) - 32'sh0006_0000;
    endcase
    return longint'(w);
  endfunction

  function automatic longint pick_radius();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 64'h7fff_ffff;
    if (r == 1) return 0;
    if (r == 2) return longint'($urandom & 32'h7fff_ffff);
    return longint'($urandom_range(0, 32'h0004_0000));
  endfunction

  task automatic send_random(bit bursty);
    coord3_t a, b;
    logic [2:0] act;
    longint t;
    int r;
    r = $urandom_range(0, 99);
    foreach (a[i]) begin
      a[i] = pick_coord();
      b[i] = pick_coord();
    end
    if (r < 8) act = ACT_SET;
    else if (r < 16) act = ACT_EXT_PT;
    else if (r < 22) act = ACT_EXT_BX;
    else if (r < 40) act = ACT_TST_PT;
    else if (r < 56) act = ACT_TST_BX;
    else if (r < 72) act = ACT_SPHERE;
    else if (r < 97) act = ACT_LINE;
    else act = 3'd7;
    // set and box test usually get ordered corners
    if ((act == ACT_SET || act == ACT_TST_BX) && $urandom_range(0, 3) != 0)
      foreach (a[i]) if (a[i] > b[i]) begin
        t = a[i]; a[i] = b[i]; b[i] = t;
      end
    // lines: sometimes freeze axes so the zero-direction path is hit
    if (act == ACT_LINE)
      foreach (a[i]) if ($urandom_range(0, 3) == 0) b[i] = a[i];
    send_req(act, a, b, pick_radius());
    idle_gap(pick_gap(bursty));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start = 0;
    while (sb.hit_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    coord3_t z, mx, mn, p, q;
    longint top, bot;
    bit bursty;
    top = 64'sh0000_0000_7fff_ffff;
    bot = -64'sh0000_0000_8000_0000;
    z = '{0, 0, 0};
    mx = '{top, top, top};
    mn = '{bot, bot, bot};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: reset box, extremes, inverted corners, all zero-direction lines.
    send_req(ACT_TST_PT, z, z, 0);
    send_req(ACT_LINE, z, z, 0);
    send_req(ACT_SPHERE, mx, z, 64'h7fff_ffff);
    send_req(ACT_SPHERE, mn, z, 0);
    send_req(3'd7, mx, mn, 64'h7fff_ffff);
    send_req(ACT_EXT_PT, mn, z, 0);
    send_req(ACT_EXT_BX, z, mx, 0);
    send_req(ACT_TST_PT, mx, z, 0);
    send_req(ACT_TST_BX, mn, mx, 0);
    send_req(ACT_LINE, mn, mx, 0);
    send_req(ACT_LINE, mx, mn, 0);
    send_req(ACT_SPHERE, z, z, 1);
    // inverted box: point test fails, box test still overlaps, line sees ordered slab
    p = '{64'sh10000, 64'sh10000, 64'sh10000};
    q = '{-64'sh10000, -64'sh10000, -64'sh10000};
    send_req(ACT_SET, p, q, 0);
    send_req(ACT_TST_PT, z, z, 0);
    send_req(ACT_TST_BX, q, p, 0);
    send_req(ACT_LINE, z, z, 0);
    send_req(ACT_LINE, '{0, 0, -64'sh20000}, '{0, 0, 64'sh20000}, 0);
    send_req(ACT_LINE, '{64'sh20000, 0, 0}, '{64'sh20000, 64'sh10, 64'sh10}, 0);
    send_req(ACT_SET, mn, mx, 0);
    send_req(ACT_LINE, mn, '{top, bot, top}, 0);
    send_req(ACT_SPHERE, mx, z, 0);
    send_req(ACT_SET, mx, mn, 0);
    send_req(ACT_SPHERE, z, z, 64'h7fff_ffff);
    send_req(ACT_SET, q, p, 0);
    send_req(ACT_SPHERE, '{64'sh30000, 0, 0}, z, 64'sh20000);
    wait_drained();

    bursty = 0;
    for (int k = 0; k < N_RANDOM; k++) begin
      if (k % 100 == 0) bursty = ($urandom_range(0, 3) == 0);
      if (k == N_RANDOM / 2) wait_drained();
      send_random(bursty);
    end
    wait_drained();
    repeat (20) @(negedge clk);

    $display("sent %0d requests: set %0d, extend %0d/%0d, point %0d, box %0d, sphere %0d,",
             sent, act_count[0], act_count[1], act_count[2], act_count[3], act_count[4],
             act_count[5]);
    $display("  line %0d, unused code %0d; %0d results checked, %0d mismatches",
             act_count[6], act_count[7], sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.hit_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
